/* design/glc_pkg.sv */
// Package for the grid letter chain walker: shared types, constants, the neighbor offset table.
// No dependencies.
`timescale 1ns / 1ps
package glc_pkg;

	localparam int unsigned DEF_MAX_ROWS = 64;
	localparam int unsigned DEF_MAX_COLS = 64;
	localparam int unsigned CFG_W = 7;
	localparam int unsigned DIM_W = 9;
	localparam int unsigned LEN_W = 9;
	localparam int unsigned CHAR_W = 8;
	localparam int unsigned EXT_W = 10;
	localparam logic [CHAR_W-1:0] START_CODE = 8'd65;

	localparam logic REG_ROW_COUNT = 1'b0;
	localparam logic REG_COL_COUNT = 1'b1;

	typedef struct packed {
		logic [DIM_W-1:0] rows;
		logic [DIM_W-1:0] cols;
		logic             restart;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_POP,
		ST_POP_WAIT,
		ST_CUR_WAIT,
		ST_NB,
		ST_NB_CHK,
		ST_DONE
	} state_t;

	// Neighbor offsets, two's complement over EXT_W bits
	function automatic logic [EXT_W-1:0] step_row(input logic [2:0] k);
		logic [EXT_W-1:0] v;
		unique case (k)
			3'd0, 3'd1: v = '0;
			3'd2, 3'd4, 3'd6: v = EXT_W'(1);
			default: v = '1;
		endcase
		return v;
	endfunction

	function automatic logic [EXT_W-1:0] step_col(input logic [2:0] k);
		logic [EXT_W-1:0] v;
		unique case (k)
			3'd2, 3'd3: v = '0;
			3'd0, 3'd4, 3'd7: v = EXT_W'(1);
			default: v = '1;
		endcase
		return v;
	endfunction

endpackage

/* design/grid_letter_chain_bfs_core.sv */
// Channel    | Ports                              | Handshake
// cfg        | cfg_wr_en, cfg_addr, cfg_wdata      | write when cfg_wr_en high
// cell in    | cell_char                           | taken when start && !busy
// result out | longest_path                        | valid one cycle while done high
//
// Cells load at one per cycle while busy is low. After the last cell the walk takes each
// queued cell through ST_POP, ST_POP_WAIT, ST_CUR_WAIT, then each neighbor through ST_NB
// (and ST_NB_CHK if in-grid), paced by the grid memory's single read port; ST_DONE follows
// once the queue is empty. busy is high from the last cell to the done strobe. Reset clears
// control state only; a config write restarts loading. The receiver cannot stall the result.
// Depends on glc_pkg, glc_ctrl, glc_ram.
`timescale 1ns / 1ps
module grid_letter_chain_bfs_core #(
	parameter int unsigned MAX_ROWS = glc_pkg::DEF_MAX_ROWS,
	parameter int unsigned MAX_COLS = glc_pkg::DEF_MAX_COLS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic                       cfg_addr,
	input  logic [glc_pkg::CFG_W-1:0]  cfg_wdata,
	input  logic                       start,
	input  logic [glc_pkg::CHAR_W-1:0] cell_char,
	output logic                       busy,
	output logic                       done,
	output logic [glc_pkg::LEN_W-1:0]  longest_path
);

	logic [glc_pkg::CFG_W-1:0] row_count_q, col_count_q;
	glc_pkg::cfg_t cfg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= glc_pkg::CFG_W'(1);
			col_count_q <= glc_pkg::CFG_W'(1);
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				glc_pkg::REG_ROW_COUNT: row_count_q <= cfg_wdata;
				glc_pkg::REG_COL_COUNT: col_count_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// clamp dimensions into 1..MAX
	always_comb begin
		cfg.restart = cfg_wr_en;
		if (row_count_q == '0) begin
			cfg.rows = glc_pkg::DIM_W'(1);
		end else if (glc_pkg::DIM_W'(row_count_q) > glc_pkg::DIM_W'(MAX_ROWS)) begin
			cfg.rows = glc_pkg::DIM_W'(MAX_ROWS);
		end else begin
			cfg.rows = glc_pkg::DIM_W'(row_count_q);
		end
		if (col_count_q == '0) begin
			cfg.cols = glc_pkg::DIM_W'(1);
		end else if (glc_pkg::DIM_W'(col_count_q) > glc_pkg::DIM_W'(MAX_COLS)) begin
			cfg.cols = glc_pkg::DIM_W'(MAX_COLS);
		end else begin
			cfg.cols = glc_pkg::DIM_W'(col_count_q);
		end
	end

	glc_ctrl #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .start(start), .cell_char(cell_char),
		.busy(busy), .done(done), .longest_path(longest_path)
	);

endmodule

/* design/glc_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module glc_ram #(
	parameter int unsigned WIDTH  = 8,
	parameter int unsigned DEPTH  = 4096,
	parameter int unsigned ADDR_W = 12
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* design/glc_ctrl.sv */
// Load sequencer and breadth-first walk over the grid and queue memories.
// Depends on glc_pkg and glc_ram.
`timescale 1ns / 1ps
module glc_ctrl #(
	parameter int unsigned MAX_ROWS = glc_pkg::DEF_MAX_ROWS,
	parameter int unsigned MAX_COLS = glc_pkg::DEF_MAX_COLS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  glc_pkg::cfg_t               cfg,
	input  logic                        start,
	input  logic [glc_pkg::CHAR_W-1:0]  cell_char,
	output logic                        busy,
	output logic                        done,
	output logic [glc_pkg::LEN_W-1:0]   longest_path
);

	localparam int unsigned ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int unsigned COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int unsigned GA_W  = ROW_W + COL_W;
	localparam int unsigned G_DEPTH = (1 << GA_W);
	localparam int unsigned Q_DEPTH = MAX_ROWS * MAX_COLS;
	localparam int unsigned QA_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int unsigned G_W   = glc_pkg::CHAR_W + 1;
	localparam int unsigned Q_W   = GA_W + glc_pkg::LEN_W;

	glc_pkg::state_t state_q, state_d;

	logic [ROW_W-1:0]          row_q;
	logic [COL_W-1:0]          col_q;
	logic [QA_W:0]             head_q, tail_q;
	logic [glc_pkg::LEN_W-1:0] best_q, cur_len_q;
	logic [ROW_W-1:0]          cur_row_q;
	logic [COL_W-1:0]          cur_col_q;
	logic [glc_pkg::CHAR_W-1:0] want_q;
	logic [2:0]                k_q;
	logic [GA_W-1:0]           nb_addr_q;

	logic             g_we;
	logic [GA_W-1:0]  g_waddr, g_raddr;
	logic [G_W-1:0]   g_wdata, g_rdata;
	logic             q_we;
	logic [QA_W-1:0]  q_waddr, q_raddr;
	logic [Q_W-1:0]   q_wdata, q_rdata;

	logic [glc_pkg::EXT_W-1:0] nr, nc;
	logic inb, hit, last_cell, accept;

	glc_ram #(.WIDTH(G_W), .DEPTH(G_DEPTH), .ADDR_W(GA_W)) u_grid (
		.clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
		.raddr(g_raddr), .rdata(g_rdata)
	);

	glc_ram #(.WIDTH(Q_W), .DEPTH(Q_DEPTH), .ADDR_W(QA_W)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
		.raddr(q_raddr), .rdata(q_rdata)
	);

	assign busy   = (state_q != glc_pkg::ST_LOAD);
	assign accept = start && !busy;
	assign done   = (state_q == glc_pkg::ST_DONE);
	assign longest_path = best_q;

	assign last_cell = (glc_pkg::DIM_W'(row_q) == cfg.rows - glc_pkg::DIM_W'(1)) &&
	                   (glc_pkg::DIM_W'(col_q) == cfg.cols - glc_pkg::DIM_W'(1));

	assign nr  = glc_pkg::EXT_W'(cur_row_q) + glc_pkg::step_row(k_q);
	assign nc  = glc_pkg::EXT_W'(cur_col_q) + glc_pkg::step_col(k_q);
	assign inb = !nr[glc_pkg::EXT_W-1] && !nc[glc_pkg::EXT_W-1] &&
	             (nr[glc_pkg::DIM_W-1:0] < cfg.rows) && (nc[glc_pkg::DIM_W-1:0] < cfg.cols);
	assign hit = !g_rdata[glc_pkg::CHAR_W] && (g_rdata[glc_pkg::CHAR_W-1:0] == want_q);

	always_comb begin
		state_d = state_q;
		g_we    = 1'b0;
		g_waddr = {row_q, col_q};
		g_wdata = {cell_char == glc_pkg::START_CODE, cell_char};
		g_raddr = nb_addr_q;
		q_we    = 1'b0;
		q_waddr = tail_q[QA_W-1:0];
		q_wdata = {row_q, col_q, glc_pkg::LEN_W'(1)};
		q_raddr = head_q[QA_W-1:0];
		unique case (state_q)
			glc_pkg::ST_LOAD: begin
				if (accept) begin
					g_we = 1'b1;
					q_we = (cell_char == glc_pkg::START_CODE);
					if (last_cell) begin
						state_d = glc_pkg::ST_POP;
					end
				end
			end
			glc_pkg::ST_POP: begin
				state_d = (head_q == tail_q) ? glc_pkg::ST_DONE : glc_pkg::ST_POP_WAIT;
			end
			glc_pkg::ST_POP_WAIT: begin
				g_raddr = q_rdata[Q_W-1:glc_pkg::LEN_W];
				state_d = glc_pkg::ST_CUR_WAIT;
			end
			glc_pkg::ST_CUR_WAIT: begin
				state_d = glc_pkg::ST_NB;
			end
			glc_pkg::ST_NB: begin
				g_raddr = {nr[ROW_W-1:0], nc[COL_W-1:0]};
				if (inb) begin
					state_d = glc_pkg::ST_NB_CHK;
				end else if (k_q == 3'd7) begin
					state_d = glc_pkg::ST_POP;
				end
			end
			glc_pkg::ST_NB_CHK: begin
				g_waddr = nb_addr_q;
				g_wdata = {1'b1, g_rdata[glc_pkg::CHAR_W-1:0]};
				q_wdata = {nb_addr_q, cur_len_q + glc_pkg::LEN_W'(1)};
				if (hit) begin
					g_we = 1'b1;
					q_we = 1'b1;
				end
				state_d = (k_q == 3'd7) ? glc_pkg::ST_POP : glc_pkg::ST_NB;
			end
			glc_pkg::ST_DONE: begin
				state_d = glc_pkg::ST_LOAD;
			end
			default: state_d = glc_pkg::ST_LOAD;
		endcase
		if (cfg.restart) begin
			state_d = glc_pkg::ST_LOAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= glc_pkg::ST_LOAD;
			row_q   <= '0;
			col_q   <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			best_q  <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (q_we) begin
				tail_q <= tail_q + 1'b1;
			end
			unique case (state_q)
				glc_pkg::ST_LOAD: begin
					if (accept) begin
						// advance row-major load position
						if (glc_pkg::DIM_W'(col_q) == cfg.cols - glc_pkg::DIM_W'(1)) begin
							col_q <= '0;
							row_q <= last_cell ? '0 : row_q + 1'b1;
						end else begin
							col_q <= col_q + 1'b1;
						end
					end
				end
				glc_pkg::ST_POP: begin
					if (head_q != tail_q) begin
						head_q <= head_q + 1'b1;
					end
				end
				glc_pkg::ST_POP_WAIT: begin
					best_q <= q_rdata[glc_pkg::LEN_W-1:0];
				end
				glc_pkg::ST_CUR_WAIT: begin
					k_q <= '0;
				end
				glc_pkg::ST_NB: begin
					if (!inb) begin
						k_q <= k_q + 1'b1;
					end
				end
				glc_pkg::ST_NB_CHK: begin
					k_q <= k_q + 1'b1;
				end
				glc_pkg::ST_DONE: begin
					head_q <= '0;
					tail_q <= '0;
					best_q <= '0;
				end
				default: ;
			endcase
			if (cfg.restart) begin
				row_q  <= '0;
				col_q  <= '0;
				head_q <= '0;
				tail_q <= '0;
				best_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == glc_pkg::ST_POP_WAIT) begin
			cur_row_q <= q_rdata[Q_W-1:COL_W+glc_pkg::LEN_W];
			cur_col_q <= q_rdata[COL_W+glc_pkg::LEN_W-1:glc_pkg::LEN_W];
			cur_len_q <= q_rdata[glc_pkg::LEN_W-1:0];
		end
		if (state_q == glc_pkg::ST_CUR_WAIT) begin
			want_q <= g_rdata[glc_pkg::CHAR_W-1:0] + 1'b1;
		end
		if (state_q == glc_pkg::ST_NB) begin
			nb_addr_q <= {nr[ROW_W-1:0], nc[COL_W-1:0]};
		end
	end

	a_head_le_tail: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q) else $error("queue head passed tail");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_we |-> tail_q < (QA_W+1)'(Q_DEPTH)) else $error("queue push while full");
	a_done_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe held");
	a_walk_on_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == glc_pkg::ST_POP && head_q == tail_q && !cfg.restart) |=> done)
		else $error("walk did not finish on empty queue");

endmodule

/* bench/grid_letter_chain_bfs_core_test.sv */
// Self-checking bench for grid_letter_chain_bfs_core: loads character grids, predicts the
// longest consecutive-letter chain from each 'A' cell, and compares every done strobe.
// Depends on glc_pkg and the grid_letter_chain_bfs_core RTL.
`timescale 1ns / 1ps
module grid_letter_chain_bfs_core_test;

	localparam int unsigned GRID_ROWS = 64;
	localparam int unsigned GRID_COLS = 64;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_wr_en;
	logic                       cfg_addr;
	logic [glc_pkg::CFG_W-1:0]  cfg_wdata;
	logic                       start;
	logic [glc_pkg::CHAR_W-1:0] cell_char;
	logic                       busy;
	logic                       done;
	logic [glc_pkg::LEN_W-1:0]  longest_path;

	grid_letter_chain_bfs_core DUT (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata), .start(start), .cell_char(cell_char), .busy(busy),
		.done(done), .longest_path(longest_path)
	);

	// Shadow of the block's state
	logic [glc_pkg::CFG_W-1:0]  row_setting;
	logic [glc_pkg::CFG_W-1:0]  col_setting;
	logic [glc_pkg::CHAR_W-1:0] grid_codes [GRID_ROWS*GRID_COLS];
	bit                         grid_seen [GRID_ROWS*GRID_COLS];
	int unsigned                load_index;
	int unsigned                chain_row [$];
	int unsigned                chain_col [$];
	int unsigned                chain_len [$];

	logic [glc_pkg::LEN_W-1:0]  expected_lengths [$];
	int                         error_count;
	int                         cells_sent;
	bit                         steady_feed;

	initial begin
		clk = 1'b0;
	end
	always #5 clk = ~clk;

	function automatic int unsigned active_dim(logic [glc_pkg::CFG_W-1:0] v, int unsigned lim);
		if (v == 0) return 1;
		if (v > lim) return lim;
		return v;
	endfunction

	function automatic void clear_load();
		load_index = 0;
		chain_row.delete();
		chain_col.delete();
		chain_len.delete();
		foreach (grid_seen[i]) grid_seen[i] = 1'b0;
	endfunction

	// Breadth-first walk from the queued 'A' cells; the last length popped is the longest
	function automatic logic [glc_pkg::LEN_W-1:0] walk_longest_chain(int unsigned rows,
		int unsigned cols);
		int unsigned                best;
		int unsigned                r, c, len;
		int                         nr, nc, idx;
		logic [glc_pkg::CHAR_W-1:0] want;
		int                         dr [8] = '{0, 0, 1, -1, 1, -1, 1, -1};
		int                         dc [8] = '{1, -1, 0, 0, 1, -1, -1, 1};
		best = 0;
		while (chain_len.size() > 0) begin
			r = chain_row.pop_front();
			c = chain_col.pop_front();
			len = chain_len.pop_front();
			best = len;
			want = grid_codes[r*GRID_COLS + c] + 8'd1;
			for (int k = 0; k < 8; k++) begin
				nr = int'(r) + dr[k];
				nc = int'(c) + dc[k];
				if (nr < 0 || nc < 0 || nr >= int'(rows) || nc >= int'(cols)) continue;
				idx = nr*GRID_COLS + nc;
				if (grid_codes[idx] == want && !grid_seen[idx]) begin
					grid_seen[idx] = 1'b1;
					chain_row.push_back(nr);
					chain_col.push_back(nc);
					chain_len.push_back(len + 1);
				end
			end
		end
		return glc_pkg::LEN_W'(best);
	endfunction

	function automatic void predict_cell(logic [glc_pkg::CHAR_W-1:0] ch);
		int unsigned rows, cols, idx;
		rows = active_dim(row_setting, GRID_ROWS);
		cols = active_dim(col_setting, GRID_COLS);
		if (load_index >= rows*cols) load_index = 0;
		idx = (load_index / cols)*GRID_COLS + (load_index % cols);
		grid_codes[idx] = ch;
		if (ch == glc_pkg::START_CODE) begin
			grid_seen[idx] = 1'b1;
			chain_row.push_back(load_index / cols);
			chain_col.push_back(load_index % cols);
			chain_len.push_back(1);
		end
		load_index++;
		if (load_index == rows*cols) begin
			expected_lengths.push_back(walk_longest_chain(rows, cols));
			clear_load();
		end
	endfunction

	// Send one cell; transaction completes at the edge where start is high and busy low
	task automatic send_cell(input logic [glc_pkg::CHAR_W-1:0] ch);
		int unsigned gap;
		@(negedge clk);
		gap = steady_feed ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		cell_char = ch;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_cell(ch);
		cells_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start = 1'b0;
		while (expected_lengths.size() > 0) @(negedge clk);
		// let the core return to loading after the last done strobe
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [glc_pkg::CFG_W-1:0] val);
		@(negedge clk);
		start = 1'b0;
		cfg_wr_en = 1'b1;
		cfg_addr = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		if (idx == glc_pkg::REG_ROW_COUNT) row_setting = val;
		else col_setting = val;
		clear_load();
	endtask

	task automatic set_size(input logic [glc_pkg::CFG_W-1:0] rows,
		input logic [glc_pkg::CFG_W-1:0] cols);
		wait_drained();
		write_reg(glc_pkg::REG_ROW_COUNT, rows);
		write_reg(glc_pkg::REG_COL_COUNT, cols);
	endtask

	function automatic logic [glc_pkg::CHAR_W-1:0] chain_biased_code();
		if ($urandom_range(0, 4) == 0) return glc_pkg::CHAR_W'($urandom);
		return glc_pkg::START_CODE + glc_pkg::CHAR_W'($urandom_range(0, 6));
	endfunction

	task automatic load_random_grid();
		int unsigned rows, cols;
		rows = active_dim(row_setting, GRID_ROWS);
		cols = active_dim(col_setting, GRID_COLS);
		for (int i = 0; i < rows*cols; i++) send_cell(chain_biased_code());
	endtask

	task automatic test_single_cell();
		set_size(7'd0, 7'd0);
		send_cell(glc_pkg::START_CODE);
		send_cell(8'd0);
		send_cell(8'd255);
		send_cell(glc_pkg::START_CODE + 8'd1);
	endtask

	task automatic test_uniform_grids();
		set_size(7'd3, 7'd3);
		repeat (9) send_cell(glc_pkg::START_CODE);
		repeat (9) send_cell(8'd0);
	endtask

	task automatic test_restart_mid_grid();
		set_size(7'd2, 7'd2);
		send_cell(glc_pkg::START_CODE);
		send_cell(glc_pkg::START_CODE + 8'd1);
		// drop the partial grid
		wait_drained();
		write_reg(glc_pkg::REG_COL_COUNT, 7'd3);
		send_cell(8'd7);
		send_cell(glc_pkg::START_CODE);
		send_cell(8'd9);
		send_cell(glc_pkg::START_CODE + 8'd1);
		send_cell(8'd3);
		send_cell(glc_pkg::START_CODE + 8'd2);
	endtask

	// Snake through a 16x16 grid: 256 consecutive codes from 'A', wrapping past 255
	task automatic test_snake_wrap();
		set_size(7'd16, 7'd16);
		steady_feed = 1'b1;
		for (int r = 0; r < 16; r++)
			for (int c = 0; c < 16; c++)
				send_cell(glc_pkg::START_CODE +
					glc_pkg::CHAR_W'(r*16 + ((r % 2) ? 15 - c : c)));
		steady_feed = 1'b0;
	endtask

	task automatic test_largest_grid();
		set_size(7'd127, 7'd1);
		load_random_grid();
		set_size(7'd1, 7'd127);
		steady_feed = 1'b1;
		load_random_grid();
		steady_feed = 1'b0;
	endtask

	task automatic test_random_grids();
		while (cells_sent < 1500) begin
			if ($urandom_range(0, 3) == 0)
				set_size(7'($urandom_range(1, 12)), 7'($urandom_range(1, 12)));
			else if ($urandom_range(0, 7) == 0)
				set_size(7'($urandom_range(0, 5)), 7'($urandom_range(0, 5)));
			steady_feed = ($urandom_range(0, 3) == 0);
			load_random_grid();
		end
		steady_feed = 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_lengths.size() == 0) begin
				$display("%0t: result %0d with none expected", $time, longest_path);
				error_count++;
			end else begin
				if (longest_path !== expected_lengths[0]) begin
					$display("%0t: longest_path expected %0d actual %0d", $time,
						expected_lengths[0], longest_path);
					error_count++;
				end
				void'(expected_lengths.pop_front());
			end
		end
	end

	initial begin
		int unsigned settle;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_addr = glc_pkg::REG_ROW_COUNT;
		cfg_wdata = '0;
		start = 1'b0;
		cell_char = '0;
		error_count = 0;
		cells_sent = 0;
		steady_feed = 1'b0;
		row_setting = 7'd1;
		col_setting = 7'd1;
		foreach (grid_codes[i]) grid_codes[i] = '0;
		clear_load();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_cell(glc_pkg::START_CODE);
		test_single_cell();
		test_uniform_grids();
		test_restart_mid_grid();
		test_snake_wrap();
		test_largest_grid();
		test_random_grids();

		@(negedge clk);
		start = 1'b0;
		settle = 0;
		while (expected_lengths.size() > 0 && settle < 200000) begin
			@(negedge clk);
			settle++;
		end
		if (expected_lengths.size() > 0) begin
			$display("%0t: %0d results never arrived", $time, expected_lengths.size());
			error_count++;
		end
		repeat (30) @(negedge clk);
		if (error_count == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#10ms;
		$display("Timeout at %0t", $time);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
